FILE: hdl/tid_pkg.sv
// Shared widths, register indexes and controller/datapath types for the integrator block.
`default_nettype none

package tid_pkg;

  // Widths of the sample fields as used by the arithmetic.
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned TIME_WIDTH  = 32;

  // Port and result widths.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned SLOPE_W    = 48;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MIN_INT_W  = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Magnitude of a sum or difference of two values needs one extra bit.
  localparam int unsigned MAG_W     = VALUE_WIDTH + 1;
  localparam int unsigned PROD_W    = MAG_W + TIME_WIDTH;
  localparam int unsigned DVD_W     = MAG_W + FRAC_BITS;
  localparam int unsigned MUL_STEPS = TIME_WIDTH;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned NUM_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
  localparam int unsigned CNT_W     = $clog2(NUM_STEPS + 1);
  // The product never exceeds ACC_W + 1 bits, so two guard bits suffice.
  localparam int unsigned ACC_EXT_W = ACC_W + 2;
  localparam int unsigned QEXT_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTEGRATE_ENABLE  = 2'd0,
    CFG_DERIVATIVE_ENABLE = 2'd1,
    CFG_MIN_INTERVAL      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic commit;
  } tid_cmd_t;

  typedef struct packed {
    logic prev_valid;
  } tid_status_t;

endpackage

`default_nettype wire

FILE: hdl/tid_datapath.sv
// Datapath: sample history, shift-add multiplier, restoring divider and result registers.
`default_nettype none

module tid_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [tid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [tid_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire  [tid_pkg::SAMPLE_W-1:0]      sample_value_i,
  input  wire  [tid_pkg::SAMPLE_W-1:0]      sample_time_i,
  input  tid_pkg::tid_cmd_t                 cmd_i,
  output tid_pkg::tid_status_t              status_o,
  output logic signed [tid_pkg::ACC_W-1:0]  integral_twice_area_o,
  output logic signed [tid_pkg::SLOPE_W-1:0] derivative_q16_o,
  output logic                              updated_o
);
  import tid_pkg::*;

  localparam logic signed [ACC_EXT_W-1:0] ACC_MAX_EXT =
    {2'b00, 1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_EXT_W-1:0] ACC_MIN_EXT =
    {2'b11, 1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [QEXT_W-1:0] SLOPE_POS_LIM = QEXT_W'((64'd1 << (SLOPE_W-1)) - 64'd1);
  localparam logic [QEXT_W-1:0] SLOPE_NEG_LIM = QEXT_W'(64'd1 << (SLOPE_W-1));

  // Configuration registers.
  logic                 int_en_q;
  logic                 der_en_q;
  logic [MIN_INT_W-1:0] min_interval_q;

  // Sample history.
  logic [VALUE_WIDTH-1:0] prev_value_q;
  logic [TIME_WIDTH-1:0]  prev_time_q;
  logic                   prev_valid_q;

  // Per-item working registers.
  logic                  upd_q;
  logic                  sum_neg_q;
  logic                  diff_neg_q;
  logic [TIME_WIDTH-1:0] dt_q;
  logic [PROD_W-1:0]     mcand_q, mcand_d;
  logic [TIME_WIDTH-1:0] mplier_q, mplier_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [DVD_W-1:0]      dvd_q, dvd_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]      quo_q, quo_d;

  // Results, held until the next item commits.
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SLOPE_W-1:0] slope_q, slope_d;
  logic                      updated_q;

  logic signed [MAG_W-1:0] cur_ext, prev_ext, sum_w, diff_w;
  logic [MAG_W-1:0]        sum_mag, diff_mag;
  logic [TIME_WIDTH-1:0]   dt_w;
  logic [TIME_WIDTH:0]     rem_sh;
  logic [TIME_WIDTH:0]     dt_ext;
  logic                    rem_ge;
  logic signed [ACC_EXT_W-1:0] acc_ext, prod_ext, acc_sum;
  logic [QEXT_W-1:0]       quo_ext, quo_clip;
  logic [SLOPE_W-1:0]      slope_calc;

  assign status_o.prev_valid = prev_valid_q;

  // Operand preparation at load time.
  always_comb begin
    cur_ext  = {sample_value_i[VALUE_WIDTH-1], sample_value_i[VALUE_WIDTH-1:0]};
    prev_ext = {prev_value_q[VALUE_WIDTH-1], prev_value_q};
    sum_w    = cur_ext + prev_ext;
    diff_w   = cur_ext - prev_ext;
    sum_mag  = sum_w[MAG_W-1]  ? (~sum_w + 1'b1)  : sum_w;
    diff_mag = diff_w[MAG_W-1] ? (~diff_w + 1'b1) : diff_w;
    dt_w     = sample_time_i[TIME_WIDTH-1:0] - prev_time_q;
  end

  // One shift-add multiplier step and one restoring divider step.
  always_comb begin
    prod_d   = mplier_q[0] ? (prod_q + mcand_q) : prod_q;
    mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
    mplier_d = {1'b0, mplier_q[TIME_WIDTH-1:1]};

    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    dt_ext = {1'b0, dt_q};
    rem_ge = (rem_sh >= dt_ext);
    if (rem_ge) begin
      rem_d = TIME_WIDTH'(rem_sh - dt_ext);
    end else begin
      rem_d = rem_sh[TIME_WIDTH-1:0];
    end
    quo_d = {quo_q[DVD_W-2:0], rem_ge};
    dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
  end

  // Saturating accumulate and saturated slope, applied at commit.
  always_comb begin
    acc_ext  = {{2{acc_q[ACC_W-1]}}, acc_q};
    prod_ext = {{(ACC_EXT_W-PROD_W){1'b0}}, prod_q};
    acc_sum  = sum_neg_q ? (acc_ext - prod_ext) : (acc_ext + prod_ext);

    quo_ext  = {{(QEXT_W-DVD_W){1'b0}}, quo_q};
    if (diff_neg_q) begin
      quo_clip = (quo_ext > SLOPE_NEG_LIM) ? SLOPE_NEG_LIM : quo_ext;
    end else begin
      quo_clip = (quo_ext > SLOPE_POS_LIM) ? SLOPE_POS_LIM : quo_ext;
    end

    if ((dt_q == '0) || (dt_q < TIME_WIDTH'(min_interval_q))) begin
      slope_calc = '0;
    end else if (diff_neg_q) begin
      slope_calc = ~quo_clip[SLOPE_W-1:0] + 1'b1;
    end else begin
      slope_calc = quo_clip[SLOPE_W-1:0];
    end

    acc_d   = acc_q;
    slope_d = slope_q;
    if (upd_q && int_en_q) begin
      if (acc_sum > ACC_MAX_EXT) begin
        acc_d = ACC_MAX_EXT[ACC_W-1:0];
      end else if (acc_sum < ACC_MIN_EXT) begin
        acc_d = ACC_MIN_EXT[ACC_W-1:0];
      end else begin
        acc_d = acc_sum[ACC_W-1:0];
      end
    end
    if (upd_q && der_en_q) begin
      slope_d = slope_calc;
    end
  end

  // Control-side state: configuration, history and results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_en_q       <= 1'b0;
      der_en_q       <= 1'b0;
      min_interval_q <= MIN_INT_W'(1);
      prev_value_q   <= '0;
      prev_time_q    <= '0;
      prev_valid_q   <= 1'b0;
      acc_q          <= '0;
      slope_q        <= '0;
      updated_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_INTEGRATE_ENABLE:  int_en_q       <= cfg_data_i[0];
          CFG_DERIVATIVE_ENABLE: der_en_q       <= cfg_data_i[0];
          CFG_MIN_INTERVAL:      min_interval_q <= cfg_data_i[MIN_INT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        prev_value_q <= sample_value_i[VALUE_WIDTH-1:0];
        prev_time_q  <= sample_time_i[TIME_WIDTH-1:0];
        prev_valid_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q     <= acc_d;
        slope_q   <= slope_d;
        updated_q <= upd_q;
      end
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      upd_q      <= prev_valid_q;
      sum_neg_q  <= sum_w[MAG_W-1];
      diff_neg_q <= diff_w[MAG_W-1];
      dt_q       <= dt_w;
      mcand_q    <= {{(PROD_W-MAG_W){1'b0}}, sum_mag};
      mplier_q   <= dt_w;
      prod_q     <= '0;
      dvd_q      <= {diff_mag, {FRAC_BITS{1'b0}}};
      rem_q      <= '0;
      quo_q      <= '0;
    end else begin
      if (cmd_i.mul_step) begin
        prod_q   <= prod_d;
        mcand_q  <= mcand_d;
        mplier_q <= mplier_d;
      end
      if (cmd_i.div_step) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        dvd_q <= dvd_d;
      end
    end
  end

  assign integral_twice_area_o = acc_q;
  assign derivative_q16_o      = slope_q;
  assign updated_o             = updated_q;

endmodule

`default_nettype wire

FILE: hdl/tid_ctrl.sv
// Controller: sequences load, the multiply/divide iterations and the result commit.
`default_nettype none

module tid_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  tid_pkg::tid_status_t status_i,
  output tid_pkg::tid_cmd_t    cmd_o
);
  import tid_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          count_d    = '0;
          // Without an earlier sample there is nothing to compute.
          state_d    = status_i.prev_valid ? ST_RUN : ST_COMMIT;
        end
      end
      ST_RUN: begin
        cmd_o.mul_step = (count_q < CNT_W'(MUL_STEPS));
        cmd_o.div_step = (count_q < CNT_W'(DIV_STEPS));
        count_d        = count_q + 1'b1;
        if (count_q == CNT_W'(NUM_STEPS - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/trapezoid_integral_and_derivative.sv
// Top level of the trapezoidal integrator and finite-difference differentiator.
//
// Usage: each input transfer carries a signed sample value and its capture time in
// ticks. For every input transfer exactly one output transfer follows, carrying the
// running accumulator of (current + previous) * dt (twice the trapezoid area,
// saturating at the 64-bit signed limits), the slope register in Q32.16 (saturated
// to 48 bits, zero when dt is zero or below min_interval_ticks) and the updated flag.
// Sequence: a sample that has a predecessor is loaded at its input transfer, then the
// shift-add multiplier and the restoring radix-2 divider iterate side by side (the
// divider, the longer of the two, sets the number of iterations), and the item commits;
// output valid is registered at the commit. A new input is taken only in idle, once the
// previous item has committed, so the block is through with one sample before the next.
// The first sample after reset goes straight from load to commit.
// The results are the output register: a new input is taken while the previous
// result still waits, but an item commits only once that result has been transferred,
// so a stalled receiver holds the block in its commit cycle.
// Reset clears the sample history, the accumulator, the slope and the enables, and
// sets min_interval_ticks to 1. Configuration is written through cfg_we_i with
// cfg_index_i selecting the register; writes are expected while the block is idle.
`default_nettype none

module trapezoid_integral_and_derivative (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [tid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [tid_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  signed [tid_pkg::SAMPLE_W-1:0] sample_value_i,
  input  wire  [tid_pkg::SAMPLE_W-1:0]       sample_time_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [tid_pkg::ACC_W-1:0]   integral_twice_area_o,
  output logic signed [tid_pkg::SLOPE_W-1:0] derivative_q16_o,
  output logic                               updated_o
);
  import tid_pkg::*;

  // Commands from the controller and status back to it.
  tid_cmd_t    cmd;
  tid_status_t status;

  tid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the history, both iterative units and the result registers.
  tid_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .sample_value_i        (sample_value_i),
    .sample_time_i         (sample_time_i),
    .cmd_i                 (cmd),
    .status_o              (status),
    .integral_twice_area_o (integral_twice_area_o),
    .derivative_q16_o      (derivative_q16_o),
    .updated_o             (updated_o)
  );

endmodule

`default_nettype wire
